>>> src/usbcrh_pkg.sv
// Shared codes and types for the USB control request handler.
// No dependencies; used by usb_control_request_handler_core.
`timescale 1ns / 1ps
`default_nettype none

package usbcrh_pkg;

  // Event opcodes
  localparam logic [1:0] OP_SETUP   = 2'd0;
  localparam logic [1:0] OP_ADDR_OK = 2'd1;
  localparam logic [1:0] OP_BUS_RST = 2'd2;

  // Response kinds
  localparam logic [1:0] RESP_STALL = 2'd0;
  localparam logic [1:0] RESP_ZERO  = 2'd1;
  localparam logic [1:0] RESP_DATA  = 2'd2;

  // Data sources
  localparam logic [3:0] SRC_NONE    = 4'd0;
  localparam logic [3:0] SRC_DEVICE  = 4'd1;
  localparam logic [3:0] SRC_CONFIG  = 4'd2;
  localparam logic [3:0] SRC_LANG    = 4'd3;
  localparam logic [3:0] SRC_MAKER   = 4'd4;
  localparam logic [3:0] SRC_PRODUCT = 4'd5;
  localparam logic [3:0] SRC_SERIAL  = 4'd6;
  localparam logic [3:0] SRC_RATES   = 4'd7;
  localparam logic [3:0] SRC_INLINE  = 4'd8;

  // Descriptor and table sizes in bytes
  localparam logic [7:0] LEN_DEVICE  = 8'd18;
  localparam logic [7:0] LEN_CONFIG  = 8'd93;
  localparam logic [7:0] LEN_LANG    = 8'd4;
  localparam logic [7:0] LEN_MAKER   = 8'd16;
  localparam logic [7:0] LEN_PRODUCT = 8'd42;
  localparam logic [7:0] LEN_SERIAL  = 8'd18;
  localparam logic [7:0] LEN_RATES   = 8'd212;

  // Request words: bRequest in the high byte, bmRequestType in the low byte
  localparam logic [15:0] FUNC_GET_DESC   = 16'h0680;
  localparam logic [15:0] FUNC_GET_CONFIG = 16'h0880;
  localparam logic [15:0] FUNC_SET_CONFIG = 16'h0900;
  localparam logic [15:0] FUNC_SET_ADDR   = 16'h0500;
  localparam logic [15:0] FUNC_CLASS_RATE = 16'h03a1;
  localparam logic [15:0] FUNC_CLASS_NULL = 16'h02a1;
  localparam logic [15:0] FUNC_STATUS_MSK = 16'hfffc;
  localparam logic [15:0] FUNC_GET_STATUS = 16'h0080;
  localparam logic [15:0] RATE_LEN_MASK   = 16'hffc0;

  // Standard feature request codes
  localparam logic [7:0] REQ_CLEAR_FEATURE = 8'd1;
  localparam logic [7:0] REQ_SET_FEATURE   = 8'd3;

  // Descriptor types
  localparam logic [7:0] DESC_DEVICE = 8'd1;
  localparam logic [7:0] DESC_CONFIG = 8'd2;
  localparam logic [7:0] DESC_STRING = 8'd3;

  // Pending-address marker
  localparam logic [7:0] ADDR_PENDING = 8'h80;

  // One reply to a setup transaction
  typedef struct packed {
    logic [1:0]  resp;
    logic [3:0]  src;
    logic [7:0]  len;
    logic [15:0] inl;
  } reply_t;

  localparam reply_t REPLY_STALL = '{resp: RESP_STALL, src: SRC_NONE, len: 8'd0, inl: 16'd0};
  localparam reply_t REPLY_ZERO  = '{resp: RESP_ZERO, src: SRC_NONE, len: 8'd0, inl: 16'd0};

endpackage

`default_nettype wire

>>> src/usb_control_request_handler_core.sv
// USB control-endpoint standard and class request decoder.
// Depends on usbcrh_pkg for codes, sizes and the reply type.
`timescale 1ns / 1ps
`default_nettype none

// Takes one event per transaction (setup packet, address confirmed, bus reset)
// and returns exactly one reply per event: stall, zero-length status or a data
// reply naming a descriptor, table or inline bytes with a length clipped to
// wLength, along with the device address, configured flag and endpoint halt
// flags as they stand after the event. The block sustains one event per clock
// cycle while the consumer is ready. The event is captured in the input register
// and the result register loads from it, with the whole decode and state update
// done in a single pass between them. The result register frees the input side,
// so one new event is taken while a reply waits for the consumer; further events
// then stall.
// halt_bits shows endpoints 0 to 3; endpoints above 3 are held internally.
module usb_control_request_handler_core #(
  parameter int TOP_ENDPOINT = 3
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Event input
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // tdata: packet_length[7:0], request_type[15:8], request_code[23:16],
  //        request_value[39:24], request_index[55:40], request_length[71:56]
  input  wire logic [71:0] s_tdata,
  // tuser: opcode[1:0]
  input  wire logic [1:0]  s_tuser,
  // Reply output
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // tdata: data_source[3:0], data_length[11:4], inline_bytes[27:12],
  //        address_now[35:28], configured_now[36], halt_bits[40:37],
  //        class_notify[41], zero[47:42]
  output logic [47:0]      m_tdata,
  // tuser: response[1:0]
  output logic [1:0]       m_tuser
);

  localparam int HaltW = TOP_ENDPOINT + 1;
  localparam int IdxW  = $clog2(HaltW);
  localparam logic [15:0] TopIdx = 16'(TOP_ENDPOINT);

  // Input register
  logic        in_valid;
  logic [1:0]  in_op;
  logic [7:0]  in_plen;
  logic [7:0]  in_rtype;
  logic [7:0]  in_code;
  logic [15:0] in_val;
  logic [15:0] in_idx;
  logic [15:0] in_wlen;

  // Device state
  logic [7:0]       device_address;
  logic             is_configured;
  logic [HaltW-1:0] endpoint_halt;

  logic [7:0]       device_address_next;
  logic             is_configured_next;
  logic [HaltW-1:0] endpoint_halt_next;

  // Result register
  logic              out_valid;
  usbcrh_pkg::reply_t out_reply;
  logic [7:0]        out_addr;
  logic              out_cfg;
  logic [3:0]        out_halt;
  logic              out_notify;

  usbcrh_pkg::reply_t reply;
  logic              notify;
  logic              advance;
  logic [HaltW+3:0]  halt_ext;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // Capture a new event
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_op    <= s_tuser;
      in_plen  <= s_tdata[7:0];
      in_rtype <= s_tdata[15:8];
      in_code  <= s_tdata[23:16];
      in_val   <= s_tdata[39:24];
      in_idx   <= s_tdata[55:40];
      in_wlen  <= s_tdata[71:56];
    end
  end

  // Decode the event and work out the next device state
  always_comb begin
    logic [15:0]     func;
    logic            has_addr;
    logic            idx_ok;
    logic [IdxW-1:0] idx_sel;
    logic [HaltW-1:0] idx_bit;
    logic [7:0]      desc_len;
    logic [3:0]      desc_src;
    logic            desc_ok;
    logic [7:0]      desc_type;
    logic [7:0]      desc_sub;

    func      = {in_code, in_rtype};
    has_addr  = (device_address != 8'd0);
    idx_ok    = 1'b0;
    idx_sel   = in_idx[IdxW-1:0];
    idx_bit   = HaltW'(1) << idx_sel;
    desc_type = in_val[15:8];
    desc_sub  = in_val[7:0];

    device_address_next = device_address;
    is_configured_next  = is_configured;
    endpoint_halt_next  = endpoint_halt;
    reply  = usbcrh_pkg::REPLY_STALL;
    notify = 1'b0;

    // Pick the descriptor
    desc_ok  = 1'b1;
    desc_src = usbcrh_pkg::SRC_NONE;
    desc_len = 8'd0;
    if (desc_type == usbcrh_pkg::DESC_DEVICE) begin
      desc_src = usbcrh_pkg::SRC_DEVICE;
      desc_len = usbcrh_pkg::LEN_DEVICE;
    end else if (desc_type == usbcrh_pkg::DESC_CONFIG) begin
      desc_src = usbcrh_pkg::SRC_CONFIG;
      desc_len = usbcrh_pkg::LEN_CONFIG;
    end else if (desc_type == usbcrh_pkg::DESC_STRING && desc_sub == 8'd0) begin
      desc_src = usbcrh_pkg::SRC_LANG;
      desc_len = usbcrh_pkg::LEN_LANG;
    end else if (desc_type == usbcrh_pkg::DESC_STRING && desc_sub == 8'd1) begin
      desc_src = usbcrh_pkg::SRC_MAKER;
      desc_len = usbcrh_pkg::LEN_MAKER;
    end else if (desc_type == usbcrh_pkg::DESC_STRING && desc_sub == 8'd2) begin
      desc_src = usbcrh_pkg::SRC_PRODUCT;
      desc_len = usbcrh_pkg::LEN_PRODUCT;
    end else if (desc_type == usbcrh_pkg::DESC_STRING && desc_sub == 8'd3) begin
      desc_src = usbcrh_pkg::SRC_SERIAL;
      desc_len = usbcrh_pkg::LEN_SERIAL;
    end else begin
      desc_ok = 1'b0;
    end

    unique case (in_op)
      usbcrh_pkg::OP_SETUP: begin
        if (in_plen == 8'd8) begin
          if (func == usbcrh_pkg::FUNC_GET_DESC) begin
            if (desc_ok) begin
              reply.resp = usbcrh_pkg::RESP_DATA;
              reply.src  = desc_src;
              reply.len  = ({8'd0, desc_len} > in_wlen) ? in_wlen[7:0] : desc_len;
            end
          end else if (func == usbcrh_pkg::FUNC_GET_CONFIG) begin
            if (has_addr && in_wlen == 16'd1 && in_val == 16'd0 && in_idx == 16'd0) begin
              reply.resp = usbcrh_pkg::RESP_DATA;
              reply.src  = usbcrh_pkg::SRC_INLINE;
              reply.len  = 8'd1;
              reply.inl  = {15'd0, is_configured};
            end
          end else if (func == usbcrh_pkg::FUNC_SET_CONFIG) begin
            if (has_addr && in_wlen == 16'd0 && in_idx == 16'd0 &&
                (in_val == 16'd0 || in_val == 16'd1)) begin
              is_configured_next = in_val[0];
              notify             = in_val[0];
              endpoint_halt_next = endpoint_halt & HaltW'(1);
              reply              = usbcrh_pkg::REPLY_ZERO;
            end
          end else if ((func & usbcrh_pkg::FUNC_STATUS_MSK) == usbcrh_pkg::FUNC_GET_STATUS)
          begin
            if (has_addr && in_wlen == 16'd2 && in_val == 16'd0) begin
              if (in_rtype[1] == 1'b0) begin
                // Device or interface
                if (in_idx == 16'd0) begin
                  reply.resp = usbcrh_pkg::RESP_DATA;
                  reply.src  = usbcrh_pkg::SRC_INLINE;
                  reply.len  = 8'd2;
                end
              end else if (in_rtype[0] == 1'b0) begin
                // Endpoint
                if (in_idx <= TopIdx) begin
                  reply.resp = usbcrh_pkg::RESP_DATA;
                  reply.src  = usbcrh_pkg::SRC_INLINE;
                  reply.len  = 8'd2;
                  reply.inl  = {15'd0, endpoint_halt[idx_sel]};
                end
              end
            end
          end else if (func == usbcrh_pkg::FUNC_SET_ADDR) begin
            if (!is_configured && in_wlen == 16'd0 && in_idx == 16'd0 &&
                in_val[15:7] == 9'd0) begin
              device_address_next = usbcrh_pkg::ADDR_PENDING | {1'b0, in_val[6:0]};
              reply               = usbcrh_pkg::REPLY_ZERO;
            end
          end else if (func == usbcrh_pkg::FUNC_CLASS_RATE ||
                       func == usbcrh_pkg::FUNC_CLASS_NULL) begin
            if (in_val == 16'd0 && in_idx == 16'd0) begin
              reply.resp = usbcrh_pkg::RESP_DATA;
              if (in_code[0]) begin
                // Rate table, short requests rounded down to whole packets
                reply.src = usbcrh_pkg::SRC_RATES;
                if (in_wlen < {8'd0, usbcrh_pkg::LEN_RATES}) begin
                  reply.len = in_wlen[7:0] & usbcrh_pkg::RATE_LEN_MASK[7:0];
                end else begin
                  reply.len = usbcrh_pkg::LEN_RATES;
                end
              end
            end
          end else if (in_rtype < 8'd3) begin
            // Feature set and clear
            if (has_addr && in_wlen == 16'd0) begin
              if (in_val != 16'd0) begin
                reply = usbcrh_pkg::REPLY_ZERO;
              end else begin
                idx_ok = is_configured ? (in_idx <= TopIdx) : (in_idx == 16'd0);
                if (idx_ok && in_code == usbcrh_pkg::REQ_CLEAR_FEATURE) begin
                  endpoint_halt_next = endpoint_halt & ~idx_bit;
                  reply              = usbcrh_pkg::REPLY_ZERO;
                end else if (idx_ok && in_code == usbcrh_pkg::REQ_SET_FEATURE) begin
                  endpoint_halt_next = endpoint_halt | idx_bit;
                  reply              = usbcrh_pkg::REPLY_ZERO;
                end
              end
            end
          end
        end
      end
      usbcrh_pkg::OP_ADDR_OK: begin
        device_address_next = device_address & ~usbcrh_pkg::ADDR_PENDING;
      end
      usbcrh_pkg::OP_BUS_RST: begin
        device_address_next = 8'd0;
        is_configured_next  = 1'b0;
        endpoint_halt_next  = '0;
      end
      default: begin
      end
    endcase
  end

  assign halt_ext = {4'd0, endpoint_halt_next};

  // Commit state and load the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      device_address <= 8'd0;
      is_configured  <= 1'b0;
      endpoint_halt  <= '0;
    end else begin
      if (advance) begin
        out_valid      <= 1'b1;
        device_address <= device_address_next;
        is_configured  <= is_configured_next;
        endpoint_halt  <= endpoint_halt_next;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      out_reply  <= reply;
      out_addr   <= device_address_next;
      out_cfg    <= is_configured_next;
      out_halt   <= halt_ext[3:0];
      out_notify <= notify;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_reply.resp;
  assign m_tdata  = {6'd0, out_notify, out_halt, out_cfg, out_addr,
                     out_reply.inl, out_reply.len, out_reply.src};

endmodule

`default_nettype wire
